[src/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BSPRT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define BSPRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/bsprt_pkg.sv]
// ----------------------------------------------------------------------------
// bsprt_pkg
// Shared constants, types and controller/datapath interface of the BSP tracer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsprt_pkg;

  localparam int NODE_COUNT  = 4096;
  localparam int STACK_DEPTH = 64;

  localparam int NODE_AW = $clog2(NODE_COUNT);
  localparam int VIS_W   = $clog2(NODE_COUNT + 1);
  localparam int SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int SA_W    = $clog2(STACK_DEPTH);

  localparam int COORD_W  = 32;
  localparam int LINK_W   = 16;
  localparam int EPS_W    = 12;
  localparam int NRM_FRAC = 14;   // Q2.14 normals
  localparam int FRAC_W   = 28;   // split fraction bits; the fraction is Q1.28
  localparam int Q_W      = FRAC_W + 1;
  localparam int QC_W     = $clog2(Q_W);
  localparam int D_W      = 37;   // plane distance
  localparam int DEN_W    = D_W + 1;
  localparam int ACC_W    = 50;
  localparam int MA_W     = 34;
  localparam int MB_W     = 30;
  localparam int PROD_W   = MA_W + MB_W;

  localparam logic signed [LINK_W-1:0] LEAF_EMPTY = -16'sd1;
  localparam logic signed [LINK_W-1:0] LEAF_SOLID = -16'sd2;
  localparam logic signed [LINK_W-1:0] LEAF_SKY   = -16'sd3;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_RAY   = 2'd1,
    FN_POINT = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    RES_EMPTY = 2'd0,
    RES_SOLID = 2'd1,
    RES_SKY   = 2'd2,
    RES_ERROR = 2'd3
  } result_t;

  typedef enum logic [1:0] {
    KIND_X     = 2'd0,
    KIND_Y     = 2'd1,
    KIND_Z     = 2'd2,
    KIND_PLANE = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_RAY_EPS   = 1'b0,
    CFG_POINT_EPS = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MUL_SX, MUL_SY, MUL_SZ, MUL_EX, MUL_EY, MUL_EZ, MUL_SPX, MUL_SPY, MUL_SPZ
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NODE, ST_POP, ST_TRD, ST_MUL, ST_DECIDE, ST_DIV, ST_SPLIT,
    ST_PUSH, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] normal;
    logic [31:0] offset;
    logic [31:0] links;
  } node_t;

  typedef struct packed {
    logic [LINK_W-1:0]  node;
    logic [COORD_W-1:0] mx;
    logic [COORD_W-1:0] my;
    logic [COORD_W-1:0] mz;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [COORD_W-1:0] ez;
  } frame_t;

  typedef struct packed {
    logic     tbl_we;
    logic     ld_query;
    logic     tbl_rd;
    logic     visit_inc;
    logic     pop;
    logic     pop_ld;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     cap1;
    logic     cap2;
    logic     take_front;
    logic     take_back;
    logic     div_start;
    logic [2:0] mid_we;
    logic     push;
    logic     out_load;
    result_t  res;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_ray;
    logic node_neg;
    logic node_empty;
    logic node_solid;
    logic node_sky;
    logic node_oob;
    logic sp_zero;
    logic sp_full;
    logic visits_max;
    logic kind_plane;
    logic go_front;
    logic go_back;
    logic div_done;
    logic out_busy;
  } ctl_sts_t;

endpackage

`default_nettype wire

[src/bsprt_ram.sv]
// ----------------------------------------------------------------------------
// bsprt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/bsprt_div.sv]
// ----------------------------------------------------------------------------
// bsprt_div
// Restoring divider for the split fraction: quo = floor(num * 2^28 / den).
// One quotient bit per cycle; num <= den is assumed.
// ----------------------------------------------------------------------------
`default_nettype none

module bsprt_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bsprt_pkg::D_W-1:0]   num,
  input  logic [bsprt_pkg::DEN_W-1:0] den,
  output logic                        done,
  output logic [bsprt_pkg::Q_W-1:0]   quo
);

  logic [bsprt_pkg::DEN_W:0]   rem;
  logic [bsprt_pkg::DEN_W-1:0] dsor;
  logic [bsprt_pkg::QC_W-1:0]  cnt;
  logic                        busy;
  logic                        ge;
  logic [bsprt_pkg::DEN_W:0]   rem_sub;

  always_comb begin
    ge      = rem >= {1'b0, dsor};
    rem_sub = ge ? (rem - {1'b0, dsor}) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + bsprt_pkg::QC_W'(1);
        if (cnt == bsprt_pkg::QC_W'(bsprt_pkg::Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= (bsprt_pkg::DEN_W + 1)'(num);
      dsor <= den;
    end else if (busy) begin
      // remainder stays below the divisor, so the shift cannot overflow
      rem <= {rem_sub[bsprt_pkg::DEN_W-1:0], 1'b0};
      quo <= {quo[bsprt_pkg::Q_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[src/bsprt_ctrl.sv]
// ----------------------------------------------------------------------------
// bsprt_ctrl
// Traversal sequencer: issues node writes, walks nodes, orders multiplies, divides and stack ops.
// ----------------------------------------------------------------------------
`default_nettype none

module bsprt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          func,
  output logic                in_ready,
  input  bsprt_pkg::ctl_sts_t sts,
  output bsprt_pkg::ctl_cmd_t cmd
);

  bsprt_pkg::state_t  state, state_next;
  logic [2:0]         cnt, cnt_next;
  bsprt_pkg::result_t res, res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsprt_pkg::ST_IDLE;
      cnt   <= '0;
      res   <= bsprt_pkg::RES_EMPTY;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      res   <= res_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    res_next   = res;
    case (state)
      bsprt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (bsprt_pkg::func_t'(func))
            bsprt_pkg::FN_RAY, bsprt_pkg::FN_POINT: state_next = bsprt_pkg::ST_NODE;
            default: begin
              res_next   = bsprt_pkg::RES_EMPTY;
              state_next = bsprt_pkg::ST_DONE;
            end
          endcase
        end
      end
      bsprt_pkg::ST_NODE: begin
        if (sts.node_neg) begin
          state_next = bsprt_pkg::ST_DONE;
          if (sts.node_solid) begin
            res_next = bsprt_pkg::RES_SOLID;
          end else if (sts.node_sky) begin
            res_next = sts.is_ray ? bsprt_pkg::RES_SKY : bsprt_pkg::RES_SOLID;
          end else if (sts.node_empty) begin
            if (sts.sp_zero) begin
              res_next = bsprt_pkg::RES_EMPTY;
            end else begin
              state_next = bsprt_pkg::ST_POP;
            end
          end else begin
            res_next = bsprt_pkg::RES_ERROR;
          end
        end else if (sts.node_oob || sts.visits_max) begin
          res_next   = bsprt_pkg::RES_ERROR;
          state_next = bsprt_pkg::ST_DONE;
        end else begin
          state_next = bsprt_pkg::ST_TRD;
        end
      end
      bsprt_pkg::ST_POP: state_next = bsprt_pkg::ST_NODE;
      bsprt_pkg::ST_TRD: begin
        cnt_next   = '0;
        state_next = sts.kind_plane ? bsprt_pkg::ST_MUL : bsprt_pkg::ST_DECIDE;
      end
      bsprt_pkg::ST_MUL: begin
        cnt_next = cnt + 3'd1;
        if ((!sts.is_ray && cnt == 3'd4) || cnt == 3'd7) begin
          state_next = bsprt_pkg::ST_DECIDE;
        end
      end
      bsprt_pkg::ST_DECIDE: begin
        if (sts.go_front || sts.go_back) begin
          state_next = bsprt_pkg::ST_NODE;
        end else if (sts.sp_full) begin
          res_next   = bsprt_pkg::RES_ERROR;
          state_next = bsprt_pkg::ST_DONE;
        end else begin
          state_next = sts.is_ray ? bsprt_pkg::ST_DIV : bsprt_pkg::ST_NODE;
        end
      end
      bsprt_pkg::ST_DIV: begin
        cnt_next = '0;
        if (sts.div_done) begin
          state_next = bsprt_pkg::ST_SPLIT;
        end
      end
      bsprt_pkg::ST_SPLIT: begin
        cnt_next = cnt + 3'd1;
        if (cnt == 3'd3) begin
          state_next = bsprt_pkg::ST_PUSH;
        end
      end
      bsprt_pkg::ST_PUSH: state_next = bsprt_pkg::ST_NODE;
      bsprt_pkg::ST_DONE: begin
        if (!sts.out_busy) begin
          state_next = bsprt_pkg::ST_IDLE;
        end
      end
      default: state_next = bsprt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.res  = res;
    in_ready = (state == bsprt_pkg::ST_IDLE);
    case (state)
      bsprt_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (bsprt_pkg::func_t'(func))
            bsprt_pkg::FN_WRITE: cmd.tbl_we = 1'b1;
            bsprt_pkg::FN_RAY, bsprt_pkg::FN_POINT: cmd.ld_query = 1'b1;
            default: ;
          endcase
        end
      end
      bsprt_pkg::ST_NODE: begin
        if (!sts.node_neg && !sts.node_oob && !sts.visits_max) begin
          cmd.tbl_rd    = 1'b1;
          cmd.visit_inc = 1'b1;
        end
        if (sts.node_neg && sts.node_empty && !sts.sp_zero) begin
          cmd.pop = 1'b1;
        end
      end
      bsprt_pkg::ST_POP: cmd.pop_ld = 1'b1;
      bsprt_pkg::ST_TRD: begin
        if (!sts.kind_plane) begin
          cmd.cap1 = 1'b1;
          cmd.cap2 = 1'b1;
        end
      end
      bsprt_pkg::ST_MUL: begin
        // products are registered and land in the cycle after their select
        case (cnt)
          3'd0: cmd.mul_sel = bsprt_pkg::MUL_SX;
          3'd1: begin
            cmd.acc_op  = bsprt_pkg::ACC_LOAD;
            cmd.mul_sel = bsprt_pkg::MUL_SY;
          end
          3'd2: begin
            cmd.acc_op  = bsprt_pkg::ACC_ADD;
            cmd.mul_sel = bsprt_pkg::MUL_SZ;
          end
          3'd3: begin
            cmd.acc_op  = bsprt_pkg::ACC_ADD;
            cmd.mul_sel = bsprt_pkg::MUL_EX;
          end
          3'd4: begin
            cmd.cap1    = 1'b1;
            cmd.acc_op  = bsprt_pkg::ACC_LOAD;
            cmd.mul_sel = bsprt_pkg::MUL_EY;
          end
          3'd5: begin
            cmd.acc_op  = bsprt_pkg::ACC_ADD;
            cmd.mul_sel = bsprt_pkg::MUL_EZ;
          end
          3'd6: cmd.acc_op = bsprt_pkg::ACC_ADD;
          default: cmd.cap2 = 1'b1;
        endcase
      end
      bsprt_pkg::ST_DECIDE: begin
        if (sts.go_front) begin
          cmd.take_front = 1'b1;
        end else if (sts.go_back) begin
          cmd.take_back = 1'b1;
        end else if (!sts.sp_full) begin
          if (sts.is_ray) begin
            cmd.div_start = 1'b1;
          end else begin
            cmd.push = 1'b1;
          end
        end
      end
      bsprt_pkg::ST_SPLIT: begin
        case (cnt)
          3'd0: cmd.mul_sel = bsprt_pkg::MUL_SPX;
          3'd1: begin
            cmd.mid_we  = 3'b001;
            cmd.mul_sel = bsprt_pkg::MUL_SPY;
          end
          3'd2: begin
            cmd.mid_we  = 3'b010;
            cmd.mul_sel = bsprt_pkg::MUL_SPZ;
          end
          default: cmd.mid_we = 3'b100;
        endcase
      end
      bsprt_pkg::ST_PUSH: cmd.push = 1'b1;
      bsprt_pkg::ST_DONE: cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[src/bsprt_dpath.sv]
// ----------------------------------------------------------------------------
// bsprt_dpath
// Tracer datapath: node table, traversal stack, distance and split arithmetic,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsprt_dpath (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          func,
  input  logic [11:0]         node_index,
  input  logic [1:0]          node_kind,
  input  logic [47:0]         node_normal,
  input  logic signed [31:0]  node_offset,
  input  logic [31:0]         node_links,
  input  logic signed [31:0]  start_x,
  input  logic signed [31:0]  start_y,
  input  logic signed [31:0]  start_z,
  input  logic signed [31:0]  end_x,
  input  logic signed [31:0]  end_y,
  input  logic signed [31:0]  end_z,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [11:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          outcome,
  output logic                trace_error,
  input  bsprt_pkg::ctl_cmd_t cmd,
  output bsprt_pkg::ctl_sts_t sts
);

  logic [bsprt_pkg::EPS_W-1:0] ray_eps, pt_eps;

  logic                                 is_ray;
  logic signed [bsprt_pkg::COORD_W-1:0] sx, sy, sz, ex, ey, ez, mx, my, mz;
  logic signed [bsprt_pkg::LINK_W-1:0]  node;
  logic [bsprt_pkg::SP_W-1:0]           sp, sp_dec;
  logic [bsprt_pkg::VIS_W-1:0]          visits;
  logic signed [bsprt_pkg::D_W-1:0]     d1, d2;
  logic                                 side;
  logic signed [bsprt_pkg::PROD_W-1:0]  prod, mul_out;
  logic signed [bsprt_pkg::ACC_W-1:0]   acc;
  logic signed [bsprt_pkg::MA_W-1:0]    ma;
  logic signed [bsprt_pkg::MB_W-1:0]    mb;

  bsprt_pkg::node_t  tbl_q, wr_node;
  bsprt_pkg::frame_t stk_q, push_frame;
  logic              tbl_we_g;

  logic signed [bsprt_pkg::LINK_W-1:0] child_f, child_b, push_child, next_child;
  logic signed [15:0]                  nx, ny, nz;
  logic signed [bsprt_pkg::D_W-1:0]    reps, peps, dist_s, dist_e;
  logic [bsprt_pkg::D_W-1:0]           abs1, abs2;
  logic [bsprt_pkg::DEN_W-1:0]         den;
  logic [bsprt_pkg::Q_W-1:0]           frac;
  logic                                div_done;
  logic                                ray_front, ray_back, pt_front, pt_back;

  // ---------------- node table ----------------
  assign tbl_we_g = cmd.tbl_we && (17'(node_index) < 17'(bsprt_pkg::NODE_COUNT));
  assign wr_node  = '{kind: node_kind, normal: node_normal, offset: node_offset,
                      links: node_links};

  bsprt_ram #(
    .WIDTH($bits(bsprt_pkg::node_t)),
    .DEPTH(bsprt_pkg::NODE_COUNT)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we_g),
    .waddr (bsprt_pkg::NODE_AW'(node_index)),
    .wdata (wr_node),
    .re    (cmd.tbl_rd),
    .raddr (node[bsprt_pkg::NODE_AW-1:0]),
    .rdata (tbl_q)
  );

  // ---------------- traversal stack ----------------
  assign sp_dec = sp - bsprt_pkg::SP_W'(1);

  always_comb begin
    child_f    = $signed(tbl_q.links[15:0]);
    child_b    = $signed(tbl_q.links[31:16]);
    // ray: far side goes on the stack; point: back child waits
    push_child = (is_ray && side) ? child_f : child_b;
    next_child = (is_ray && side) ? child_b : child_f;
    push_frame = '{node: push_child, mx: mx, my: my, mz: mz, ex: ex, ey: ey, ez: ez};
  end

  bsprt_ram #(
    .WIDTH($bits(bsprt_pkg::frame_t)),
    .DEPTH(bsprt_pkg::STACK_DEPTH)
  ) u_stk (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (sp[bsprt_pkg::SA_W-1:0]),
    .wdata (push_frame),
    .re    (cmd.pop),
    .raddr (sp_dec[bsprt_pkg::SA_W-1:0]),
    .rdata (stk_q)
  );

  // ---------------- multiplier ----------------
  assign nx = $signed(tbl_q.normal[15:0]);
  assign ny = $signed(tbl_q.normal[31:16]);
  assign nz = $signed(tbl_q.normal[47:32]);

  always_comb begin
    case (cmd.mul_sel)
      bsprt_pkg::MUL_SX: begin ma = bsprt_pkg::MA_W'(sx); mb = bsprt_pkg::MB_W'(nx); end
      bsprt_pkg::MUL_SY: begin ma = bsprt_pkg::MA_W'(sy); mb = bsprt_pkg::MB_W'(ny); end
      bsprt_pkg::MUL_SZ: begin ma = bsprt_pkg::MA_W'(sz); mb = bsprt_pkg::MB_W'(nz); end
      bsprt_pkg::MUL_EX: begin ma = bsprt_pkg::MA_W'(ex); mb = bsprt_pkg::MB_W'(nx); end
      bsprt_pkg::MUL_EY: begin ma = bsprt_pkg::MA_W'(ey); mb = bsprt_pkg::MB_W'(ny); end
      bsprt_pkg::MUL_EZ: begin ma = bsprt_pkg::MA_W'(ez); mb = bsprt_pkg::MB_W'(nz); end
      bsprt_pkg::MUL_SPX: begin
        ma = bsprt_pkg::MA_W'(ex) - bsprt_pkg::MA_W'(sx);
        mb = bsprt_pkg::MB_W'(frac);
      end
      bsprt_pkg::MUL_SPY: begin
        ma = bsprt_pkg::MA_W'(ey) - bsprt_pkg::MA_W'(sy);
        mb = bsprt_pkg::MB_W'(frac);
      end
      bsprt_pkg::MUL_SPZ: begin
        ma = bsprt_pkg::MA_W'(ez) - bsprt_pkg::MA_W'(sz);
        mb = bsprt_pkg::MB_W'(frac);
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign mul_out = ma * mb;

  // ---------------- plane distance ----------------
  function automatic logic signed [bsprt_pkg::D_W-1:0] plane_d(
    input logic [1:0]                         kind,
    input logic signed [bsprt_pkg::COORD_W-1:0] px,
    input logic signed [bsprt_pkg::COORD_W-1:0] py,
    input logic signed [bsprt_pkg::COORD_W-1:0] pz,
    input logic signed [bsprt_pkg::ACC_W-1:0]   sum,
    input logic signed [31:0]                 off
  );
    logic signed [bsprt_pkg::D_W-1:0] v;
    case (bsprt_pkg::kind_t'(kind))
      bsprt_pkg::KIND_X: v = bsprt_pkg::D_W'(px);
      bsprt_pkg::KIND_Y: v = bsprt_pkg::D_W'(py);
      bsprt_pkg::KIND_Z: v = bsprt_pkg::D_W'(pz);
      default:           v = bsprt_pkg::D_W'(sum >>> bsprt_pkg::NRM_FRAC);
    endcase
    return v - bsprt_pkg::D_W'(off);
  endfunction

  always_comb begin
    dist_s = plane_d(tbl_q.kind, sx, sy, sz, acc, $signed(tbl_q.offset));
    dist_e = plane_d(tbl_q.kind, ex, ey, ez, acc, $signed(tbl_q.offset));
  end

  // ---------------- side decisions ----------------
  always_comb begin
    reps      = bsprt_pkg::D_W'(ray_eps);
    peps      = bsprt_pkg::D_W'(pt_eps);
    ray_front = (d1 >= -reps) && (d2 >= -reps);
    ray_back  = (d1 < reps) && (d2 < reps);
    pt_front  = d1 > peps;
    pt_back   = d1 < -peps;
    abs1      = d1[bsprt_pkg::D_W-1] ? bsprt_pkg::D_W'(-d1) : bsprt_pkg::D_W'(d1);
    abs2      = d2[bsprt_pkg::D_W-1] ? bsprt_pkg::D_W'(-d2) : bsprt_pkg::D_W'(d2);
    den       = bsprt_pkg::DEN_W'(abs1) + bsprt_pkg::DEN_W'(abs2);
  end

  bsprt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (abs1),
    .den   (den),
    .done  (div_done),
    .quo   (frac)
  );

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_eps   <= 12'd410;
      pt_eps    <= '0;
      node      <= '0;
      sp        <= '0;
      visits    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (bsprt_pkg::cfg_idx_t'(cfg_index))
          bsprt_pkg::CFG_RAY_EPS:   ray_eps <= cfg_data;
          bsprt_pkg::CFG_POINT_EPS: pt_eps  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.ld_query) begin
        node   <= '0;
        sp     <= '0;
        visits <= '0;
      end
      if (cmd.visit_inc) begin
        visits <= visits + bsprt_pkg::VIS_W'(1);
      end
      if (cmd.pop) begin
        sp <= sp_dec;
      end
      if (cmd.pop_ld) begin
        node <= $signed(stk_q.node);
      end
      if (cmd.take_front) begin
        node <= child_f;
      end
      if (cmd.take_back) begin
        node <= child_b;
      end
      if (cmd.push) begin
        node <= next_child;
        sp   <= sp + bsprt_pkg::SP_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    prod <= mul_out;
    if (cmd.ld_query) begin
      is_ray <= (bsprt_pkg::func_t'(func) == bsprt_pkg::FN_RAY);
      sx <= start_x;
      sy <= start_y;
      sz <= start_z;
      ex <= end_x;
      ey <= end_y;
      ez <= end_z;
    end
    if (cmd.pop_ld && is_ray) begin
      sx <= $signed(stk_q.mx);
      sy <= $signed(stk_q.my);
      sz <= $signed(stk_q.mz);
      ex <= $signed(stk_q.ex);
      ey <= $signed(stk_q.ey);
      ez <= $signed(stk_q.ez);
    end
    if (cmd.push && is_ray) begin
      ex <= mx;
      ey <= my;
      ez <= mz;
    end
    case (cmd.acc_op)
      bsprt_pkg::ACC_LOAD: acc <= bsprt_pkg::ACC_W'(prod);
      bsprt_pkg::ACC_ADD:  acc <= acc + bsprt_pkg::ACC_W'(prod);
      default: ;
    endcase
    if (cmd.cap1) begin
      d1 <= dist_s;
    end
    if (cmd.cap2) begin
      d2 <= dist_e;
    end
    if (cmd.div_start) begin
      side <= d1[bsprt_pkg::D_W-1];
    end
    // split point: s + floor((e - s) * f / 2^28), low 32 bits
    if (cmd.mid_we[0]) begin
      mx <= sx + $signed(prod[bsprt_pkg::FRAC_W+31:bsprt_pkg::FRAC_W]);
    end
    if (cmd.mid_we[1]) begin
      my <= sy + $signed(prod[bsprt_pkg::FRAC_W+31:bsprt_pkg::FRAC_W]);
    end
    if (cmd.mid_we[2]) begin
      mz <= sz + $signed(prod[bsprt_pkg::FRAC_W+31:bsprt_pkg::FRAC_W]);
    end
    if (cmd.out_load) begin
      if (cmd.res == bsprt_pkg::RES_ERROR) begin
        outcome     <= bsprt_pkg::RES_SOLID;
        trace_error <= 1'b1;
      end else begin
        outcome     <= cmd.res;
        trace_error <= 1'b0;
      end
    end
  end

  // ---------------- status ----------------
  always_comb begin
    sts.is_ray     = is_ray;
    sts.node_neg   = node[bsprt_pkg::LINK_W-1];
    sts.node_empty = (node == bsprt_pkg::LEAF_EMPTY);
    sts.node_solid = (node == bsprt_pkg::LEAF_SOLID);
    sts.node_sky   = (node == bsprt_pkg::LEAF_SKY);
    sts.node_oob   = !node[bsprt_pkg::LINK_W-1] &&
                     ({2'b00, node[bsprt_pkg::LINK_W-2:0]} >= 17'(bsprt_pkg::NODE_COUNT));
    sts.sp_zero    = (sp == '0);
    sts.sp_full    = (sp == bsprt_pkg::SP_W'(bsprt_pkg::STACK_DEPTH));
    sts.visits_max = (visits == bsprt_pkg::VIS_W'(bsprt_pkg::NODE_COUNT));
    sts.kind_plane = (bsprt_pkg::kind_t'(tbl_q.kind) == bsprt_pkg::KIND_PLANE);
    sts.go_front   = is_ray ? ray_front : pt_front;
    sts.go_back    = is_ray ? ray_back : pt_back;
    sts.div_done   = div_done;
    sts.out_busy   = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

[src/bsp_ray_point_tracer.sv]
// ----------------------------------------------------------------------------
// bsp_ray_point_tracer
// BSP plane tree walker: node writes, segment (ray) queries and point queries.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+----------------
//   input    | func, node_*, start_*, end_*              | in_valid/in_ready
//   output   | outcome, trace_error                      | out_valid/out_ready
//   config   | cfg_index, cfg_data                       | cfg_we, no wait
//
// One transaction at a time. A node write goes through the done state to its result.
// A query visits nodes serially. A general node adds dot products on one
// shared multiplier (rays also take the end point's), a split on a ray adds
// the bit-serial divider and the split states, and a stack pop adds a state.
// Reset is synchronous; the node table and stack need no clearing pass.
// A held result stalls only the final transfer into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_ray_point_tracer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [11:0]        node_index,
  input  logic [1:0]         node_kind,
  input  logic [47:0]        node_normal,
  input  logic signed [31:0] node_offset,
  input  logic [31:0]        node_links,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] end_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         outcome,
  output logic               trace_error,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [11:0]        cfg_data
);

  bsprt_pkg::ctl_cmd_t cmd;
  bsprt_pkg::ctl_sts_t sts;

  bsprt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsprt_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .func        (func),
    .node_index  (node_index),
    .node_kind   (node_kind),
    .node_normal (node_normal),
    .node_offset (node_offset),
    .node_links  (node_links),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_z     (start_z),
    .end_x       (end_x),
    .end_y       (end_y),
    .end_z       (end_z),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .outcome     (outcome),
    .trace_error (trace_error),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire

[src/bsprt_checker.sv]
// ----------------------------------------------------------------------------
// bsprt_checker
// Port-level checks on the tracer, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bsprt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] outcome,
  input logic       trace_error
);

  `BSPRT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(trace_error))
  `BSPRT_ASSERT_NOW(a_err_solid, clk, rst, out_valid && trace_error, outcome == bsprt_pkg::RES_SOLID)
  `BSPRT_ASSERT_NOW(a_outcome_code, clk, rst, out_valid, outcome != bsprt_pkg::RES_ERROR)
  `BSPRT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind bsp_ray_point_tracer bsprt_checker u_chk (.*);

`default_nettype wire
